/* rtl/core/oll_pkg.sv */
// Package with the sizes, opcodes and cell command type of the ordered list engine.
package oll_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd4;

    typedef struct packed {
        logic                ins_en;
        logic                rem_en;
        logic [CNT_W-1:0]    ins_pos;
        logic [CNT_W-1:0]    count;
        logic [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

/* rtl/core/oll_cell.sv */
// One storage cell of the list: holds an entry, compares it and shifts with its neighbors.
module oll_cell
    import oll_pkg::*;
(
    input  logic                clk,
    input  logic [IDX_W-1:0]    cell_index,
    input  cell_cmd_t           cmd,
    input  logic                after_hit,
    input  logic [VALUE_W-1:0]  left_entry,
    input  logic [VALUE_W-1:0]  right_entry,
    output logic [VALUE_W-1:0]  entry,
    output logic                hit
);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;
    logic [CNT_W-1:0]   my_index;

    assign my_index = CNT_W'(cell_index);
    assign entry    = entry_reg;
    assign hit      = (entry_reg == cmd.value) && (my_index < cmd.count);

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            if (my_index > cmd.ins_pos)
            begin
                entry_next = left_entry;
            end
            else if (my_index == cmd.ins_pos)
            begin
                entry_next = cmd.value;
            end
        end
        else if (cmd.rem_en && after_hit)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* rtl/core/oll_first_hit.sv */
// Prefix OR tree that marks every cell at or after the first matching cell.
module oll_first_hit
    import oll_pkg::*;
(
    input  logic [DEPTH-1:0] hit,
    output logic [DEPTH-1:0] after_hit,
    output logic             any_hit
);

    localparam int LVLS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] lvl [0:LVLS];

    assign lvl[0] = hit;

    genvar l, i;
    generate
        for (l = 0; l < LVLS; l++)
        begin : g_lvl
            for (i = 0; i < DEPTH; i++)
            begin : g_bit
                if (i >= (1 << l))
                begin : g_or
                    assign lvl[l+1][i] = lvl[l][i] | lvl[l][i - (1 << l)];
                end
                else
                begin : g_pass
                    assign lvl[l+1][i] = lvl[l][i];
                end
            end
        end
    endgenerate

    assign after_hit = lvl[LVLS];
    assign any_hit   = lvl[LVLS][DEPTH-1];

endmodule

/* rtl/core/ordered_list_engine.sv */
// Top level of the ordered list engine: request decode, cell chain and result register.
// A result is registered when its request transaction is accepted and appears in the cycle after.
// Throughput: one request per cycle unless the output is stalled; all cells compare and shift in the same cycle.
// The next request is taken while a result waits, unless the output is stalled.
// Reset clears the entry count and the result valid; entries are not cleared.
module ordered_list_engine
    import oll_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            opcode,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [CNT_W-1:0]           entry_count,
    output logic                       overflow
);

    logic               accept_in;
    logic               full;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               found_reg;
    logic               found_next;
    logic               overflow_reg;
    logic               overflow_next;
    logic [CNT_W-1:0]   count_out_reg;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CNT_W-1:0]   clamp_pos;
    cell_cmd_t          cmd;
    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   after_hit;
    logic               any_hit;
    logic [VALUE_W-1:0] entry [0:DEPTH-1];

    assign accept_in = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));

    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign clamp_pos = (pos_ext >= cnt_ext) ? count_reg : CNT_W'(pos_ext);

    always_comb
    begin
        cmd.ins_en    = 1'b0;
        cmd.rem_en    = 1'b0;
        cmd.ins_pos   = '0;
        cmd.count     = count_reg;
        cmd.value     = value;
        count_next    = count_reg;
        found_next    = 1'b0;
        overflow_next = 1'b0;
        case (opcode)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (opcode == OP_PUSH_FRONT)
                begin
                    cmd.ins_pos = '0;
                end
                else if (opcode == OP_PUSH_BACK)
                begin
                    cmd.ins_pos = count_reg;
                end
                else
                begin
                    cmd.ins_pos = clamp_pos;
                end
                if (full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    cmd.ins_en = accept_in;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (any_hit)
                begin
                    cmd.rem_en = accept_in;
                    found_next = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CONTAINS:
            begin
                found_next = any_hit;
            end
            default:
            begin
                found_next = 1'b0;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [VALUE_W-1:0] left_in;
            logic [VALUE_W-1:0] right_in;
            if (i == 0)
            begin : g_first
                assign left_in = value;
            end
            else
            begin : g_left
                assign left_in = entry[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_in = entry[i];
            end
            else
            begin : g_right
                assign right_in = entry[i+1];
            end
            oll_cell u_cell
            (
                .clk         (clk),
                .cell_index  (IDX_W'(i)),
                .cmd         (cmd),
                .after_hit   (after_hit[i]),
                .left_entry  (left_in),
                .right_entry (right_in),
                .entry       (entry[i]),
                .hit         (hit[i])
            );
        end
    endgenerate

    oll_first_hit u_first_hit
    (
        .hit       (hit),
        .after_hit (after_hit),
        .any_hit   (any_hit)
    );

    assign out_valid_next = accept_in || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept_in)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            found_reg     <= found_next;
            overflow_reg  <= overflow_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign overflow    = overflow_reg;
    assign entry_count = count_out_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds capacity");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> out_valid_reg && (entry_count == count_reg))
        else $error("accepted request did not produce a matching result");

    a_overflow_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && overflow_next |=> (count_reg == CNT_W'(DEPTH)) && !found_reg)
        else $error("overflow reported while store not full");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && (opcode == OP_REMOVE) && any_hit |=>
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("removal did not reduce the entry count");
`endif

endmodule

/* tb/ordered_list_engine_tb.sv */
// Self-checking testbench for the ordered list engine: a directed table, then random requests.
`timescale 1ns / 100ps

module ordered_list_engine_tb;
    import oll_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASES       = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int DIRECTED_N   = 26;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] entry_count;
        logic             overflow;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        logic               typed;
        list_result_t       res;
    } request_row_t;

    // Rows marked typed carry their expected result; the others rely on the list model.
    localparam request_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{OP_CONTAINS,   32'h0000_0000, 5'd0,  1'b1, '{1'b0, 5'd0,  1'b0}},
        '{OP_RSVD_7,     32'hffff_ffff, 5'd31, 1'b1, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_BACK,  32'h7fff_ffff, 5'd0,  1'b1, '{1'b0, 5'd1,  1'b0}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 5'd0,  1'b1, '{1'b0, 5'd2,  1'b0}},
        '{OP_INSERT,     32'hffff_ffff, 5'd1,  1'b1, '{1'b0, 5'd3,  1'b0}},
        '{OP_INSERT,     32'h0000_0000, 5'd31, 1'b1, '{1'b0, 5'd4,  1'b0}},
        '{OP_CONTAINS,   32'h8000_0000, 5'd0,  1'b1, '{1'b1, 5'd4,  1'b0}},
        '{OP_PUSH_BACK,  32'h0000_00aa, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_FRONT, 32'h5555_5555, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'haaaa_aaaa, 5'd2,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_BACK,  32'h0000_00aa, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'h0000_0001, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'h0000_00aa, 5'd4,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_FRONT, 32'h1234_5678, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'hffff_fffe, 5'd16, 1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_BACK,  32'h8000_0001, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'h7fff_fffe, 5'd9,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_FRONT, 32'h0f0f_0f0f, 5'd0,  1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_INSERT,     32'hf0f0_f0f0, 5'd14, 1'b0, '{1'b0, 5'd0,  1'b0}},
        '{OP_PUSH_FRONT, 32'h1111_1111, 5'd0,  1'b1, '{1'b0, 5'd16, 1'b1}},
        '{OP_PUSH_BACK,  32'h2222_2222, 5'd0,  1'b1, '{1'b0, 5'd16, 1'b1}},
        '{OP_INSERT,     32'h3333_3333, 5'd3,  1'b1, '{1'b0, 5'd16, 1'b1}},
        '{OP_REMOVE,     32'h4444_4444, 5'd0,  1'b1, '{1'b0, 5'd16, 1'b0}},
        '{OP_REMOVE,     32'h0000_00aa, 5'd0,  1'b1, '{1'b1, 5'd15, 1'b0}},
        '{OP_CONTAINS,   32'h0000_00aa, 5'd0,  1'b1, '{1'b1, 5'd15, 1'b0}},
        '{OP_RSVD_5,     32'h0000_0000, 5'd0,  1'b1, '{1'b0, 5'd15, 1'b0}}
    };

    localparam int IDLE_BY_PHASE  [PHASES] = '{0, 65, 0, 24};
    localparam int STALL_BY_PHASE [PHASES] = '{0, 0, 65, 24};

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           opcode = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic [POS_W-1:0]          position = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      found;
    logic [CNT_W-1:0]          entry_count;
    logic                      overflow;

    logic [VALUE_W-1:0] held_entries [DEPTH];
    int                 held_count = 0;
    logic [VALUE_W-1:0] value_pool [8];
    list_result_t       pending_results [$];
    int                 fail_count = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;

    ordered_list_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .entry_count (entry_count),
        .overflow    (overflow)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int find_first(input logic [VALUE_W-1:0] v);
        int i;
        for (i = 0; i < held_count; i++)
        begin
            if (held_entries[i] == v)
                return i;
        end
        return -1;
    endfunction

    function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic [VALUE_W-1:0] v,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int at;
        int hit;
        int i;
        r = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT:
            begin
                if (held_count >= DEPTH)
                    r.overflow = 1'b1;
                else
                begin
                    if (op == OP_PUSH_FRONT)
                        at = 0;
                    else if (op == OP_PUSH_BACK || int'(pos) > held_count)
                        at = held_count;
                    else
                        at = int'(pos);
                    for (i = held_count; i > at; i--)
                        held_entries[i] = held_entries[i - 1];
                    held_entries[at] = v;
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                hit = find_first(v);
                if (hit >= 0)
                begin
                    for (i = hit; i + 1 < held_count; i++)
                        held_entries[i] = held_entries[i + 1];
                    held_count--;
                    r.found = 1'b1;
                end
            end
            OP_CONTAINS:
                r.found = (find_first(v) >= 0);
            default:
                r.found = 1'b0;
        endcase
        r.entry_count = CNT_W'(held_count);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (held_count > 0 && sel < 40)
            return held_entries[$urandom_range(held_count - 1)];
        if (sel < 75)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] v,
                                input logic [POS_W-1:0] pos, input logic typed,
                                input list_result_t typed_res);
        list_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= v;
        position <= pos;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_request(op, v, pos);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        list_result_t got;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got = '{found, entry_count, overflow};
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("Unexpected result transaction: found=%0b count=%0d overflow=%0b",
                             got.found, got.entry_count, got.overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.entry_count !== want.entry_count ||
                    got.overflow !== want.overflow)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("Mismatch at %0t: found %0b/%0b count %0d/%0d overflow %0b/%0b",
                                 $time, want.found, got.found, want.entry_count,
                                 got.entry_count, want.overflow, got.overflow);
                end
            end
        end
    end

    initial
    begin
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        int               sel;
        int               reach;
        bit               grow_mode;
        grow_mode = 1'b1;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7fff_ffff;
        for (int k = 4; k < 8; k++)
            value_pool[k] = $urandom_range(15);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_N; r++)
            send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].val, DIRECTED_ROWS[r].pos,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

        // Random traffic swings between filling and draining so full and empty are both hit.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            sender_idle_pct    = IDLE_BY_PHASE[phase];
            receiver_stall_pct = STALL_BY_PHASE[phase];
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if ($urandom_range(39) == 0)
                    grow_mode = !grow_mode;
                if (held_count == DEPTH && $urandom_range(3) == 0)
                    grow_mode = 1'b0;
                if (held_count == 0 && $urandom_range(1) == 0)
                    grow_mode = 1'b1;
                sel = $urandom_range(99);
                if (sel >= 95)
                begin
                    case ($urandom_range(2))
                        0: op = OP_RSVD_5;
                        1: op = OP_RSVD_6;
                        default: op = OP_RSVD_7;
                    endcase
                end
                else if (grow_mode)
                    op = (sel < 20) ? OP_PUSH_FRONT : (sel < 40) ? OP_PUSH_BACK :
                         (sel < 60) ? OP_INSERT : (sel < 78) ? OP_REMOVE : OP_CONTAINS;
                else
                    op = (sel < 8) ? OP_PUSH_FRONT : (sel < 16) ? OP_PUSH_BACK :
                         (sel < 25) ? OP_INSERT : (sel < 70) ? OP_REMOVE : OP_CONTAINS;
                reach = (held_count + 1 > 31) ? 31 : held_count + 1;
                if ($urandom_range(4) == 0)
                    pos = POS_W'($urandom_range(31));
                else
                    pos = POS_W'($urandom_range(reach));
                send_request(op, pick_value(), pos, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
